// ----- src/bit_flip_range_count_tree_core_macros.svh -----
// Assertion macros shared by the bit flip range count tree RTL.
`ifndef BIT_FLIP_RANGE_COUNT_TREE_CORE_MACROS_SVH
`define BIT_FLIP_RANGE_COUNT_TREE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define BFRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfrc same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define BFRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfrc next-cycle check failed");

`endif

// ----- src/bfrc_pkg.sv -----
// Shared constants and types of the bit flip range count tree.
`default_nettype none
package bfrc_pkg;

  localparam int SIZE       = 1024;
  localparam int TREE_DEPTH = 2 * SIZE;
  localparam int NODE_W     = $clog2(TREE_DEPTH);
  localparam int CNT_W      = $clog2(SIZE + 1);
  localparam int POS_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic OP_FLIP  = 1'b0;
  localparam logic OP_COUNT = 1'b1;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_FRD  = 7'b0000100,
    S_FWR  = 7'b0001000,
    S_CLO  = 7'b0010000,
    S_CHI  = 7'b0100000,
    S_COUT = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

// ----- src/bfrc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module bfrc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- src/bit_flip_range_count_tree_core.sv -----
// Top level of the bit flip range count tree: sequencer, shared adder and tree RAM.
`default_nettype none
`include "bit_flip_range_count_tree_core_macros.svh"
// The bit vector lives as a summation tree of 2048 one-count nodes in a single RAM
// with one write and one registered read port; one adder serves both the flip walk
// and the count accumulation. A flip is accepted, reads its leaf, then does one
// read-and-write-back per tree level up to the root; an out-of-range flip is dropped.
// A count does up to two RAM reads per level over 11 levels between entry and the
// result hand-off; a rejected count goes straight to the hand-off. in_tready is
// high only while the sequencer is idle. After reset and after every cfg write the
// tree is cleared by a pass over all 2048 nodes, one node a cycle, taking no item.
module bit_flip_range_count_tree_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [9:0] flip_position, [19:10] range_first, [29:20] range_last, [31:30] zero
  input  wire logic [bfrc_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] op
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [10:0] ones_count, [15:11] zero
  output logic      [bfrc_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [0] range_error
  output logic                                  out_tuser,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bfrc_pkg::SIZE_W-1:0]      cfg_data
);

  localparam int NW = bfrc_pkg::NODE_W;
  localparam int CW = bfrc_pkg::CNT_W;
  localparam int PW = bfrc_pkg::POS_W;
  localparam int SW = bfrc_pkg::SIZE_W;

  bfrc_pkg::state_t state_r, state_nxt;

  logic [SW-1:0] active_size_r, active_size_nxt;
  logic [NW-1:0] clr_r, clr_nxt;
  logic [NW-1:0] node_r, node_nxt;
  logic [NW:0]   lo_r, lo_nxt;
  logic [NW:0]   hi_r, hi_nxt;
  logic [CW-1:0] acc_r, acc_nxt;
  logic          err_r, err_nxt;
  logic          pend_r, pend_nxt;
  logic          leaf_r, leaf_nxt;
  logic          up_r, up_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic          out_err_r, out_err_nxt;

  logic          in_acc;
  logic          cfg_acc;
  logic [PW-1:0] in_pos;
  logic [PW-1:0] in_first;
  logic [PW-1:0] in_last;
  logic          flip_ok;
  logic          cnt_bad;
  logic [SW-1:0] cfg_size;
  logic          up;
  logic [NW:0]   hi_m;

  logic [CW-1:0] add_a;
  logic [CW-1:0] add_b;
  logic [CW-1:0] add_sum;

  logic          wr_en;
  logic [NW-1:0] wr_addr;
  logic [CW-1:0] wr_data;
  logic [NW-1:0] rd_addr;
  logic [CW-1:0] rd_data;

  bfrc_ram #(
    .WIDTH (CW),
    .DEPTH (bfrc_pkg::TREE_DEPTH)
  ) u_tree (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == bfrc_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign in_pos     = in_tdata[PW-1:0];
  assign in_first   = in_tdata[2*PW-1:PW];
  assign in_last    = in_tdata[3*PW-1:2*PW];
  assign flip_ok    = ({1'b0, in_pos} < active_size_r);
  assign cnt_bad    = (in_first > in_last) || ({1'b0, in_last} >= active_size_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(bfrc_pkg::OUT_DATA_W - CW)'(0), out_count_r};
  assign out_tuser  = out_err_r;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_size = SW'(1);
    end else if (cfg_data > SW'(bfrc_pkg::SIZE)) begin
      cfg_size = SW'(bfrc_pkg::SIZE);
    end else begin
      cfg_size = cfg_data;
    end
  end

  // shared adder: flip walk steps a node by one, count adds a node into the total
  assign up = leaf_r ? (rd_data == '0) : up_r;
  always_comb begin
    if (state_r == bfrc_pkg::S_FWR) begin
      add_a = rd_data;
      add_b = up ? CW'(1) : '1;
    end else begin
      add_a = acc_r;
      add_b = pend_r ? rd_data : '0;
    end
  end
  assign add_sum = add_a + add_b;

  always_comb begin
    state_nxt       = state_r;
    active_size_nxt = active_size_r;
    clr_nxt         = clr_r;
    node_nxt        = node_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    acc_nxt         = acc_r;
    err_nxt         = err_r;
    pend_nxt        = pend_r;
    leaf_nxt        = leaf_r;
    up_nxt          = up_r;
    out_count_nxt   = out_count_r;
    out_err_nxt     = out_err_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    wr_en           = 1'b0;
    wr_addr         = node_r;
    wr_data         = add_sum;
    rd_addr         = node_r;
    hi_m            = hi_r;

    case (state_r)
      bfrc_pkg::S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + NW'(1);
        if (clr_r == '1) begin
          state_nxt = bfrc_pkg::S_IDLE;
        end
      end
      bfrc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == bfrc_pkg::OP_FLIP) begin
            if (flip_ok) begin
              node_nxt  = NW'(bfrc_pkg::SIZE) + NW'(in_pos);
              state_nxt = bfrc_pkg::S_FRD;
            end
          end else begin
            acc_nxt   = '0;
            pend_nxt  = 1'b0;
            err_nxt   = cnt_bad;
            lo_nxt    = (NW + 1)'(bfrc_pkg::SIZE) + (NW + 1)'(in_first);
            hi_nxt    = (NW + 1)'(bfrc_pkg::SIZE) + (NW + 1)'(in_last) + (NW + 1)'(1);
            state_nxt = cnt_bad ? bfrc_pkg::S_COUT : bfrc_pkg::S_CLO;
          end
        end
      end
      bfrc_pkg::S_FRD: begin
        rd_addr   = node_r;
        leaf_nxt  = 1'b1;
        state_nxt = bfrc_pkg::S_FWR;
      end
      bfrc_pkg::S_FWR: begin
        wr_en    = 1'b1;
        wr_addr  = node_r;
        wr_data  = add_sum;
        up_nxt   = up;
        leaf_nxt = 1'b0;
        rd_addr  = node_r >> 1;
        node_nxt = node_r >> 1;
        if (node_r == NW'(1)) begin
          state_nxt = bfrc_pkg::S_IDLE;
        end
      end
      bfrc_pkg::S_CLO: begin
        acc_nxt  = add_sum;
        pend_nxt = 1'b0;
        if (lo_r < hi_r) begin
          if (lo_r[0]) begin
            rd_addr  = lo_r[NW-1:0];
            pend_nxt = 1'b1;
            lo_nxt   = lo_r + (NW + 1)'(1);
          end
          state_nxt = bfrc_pkg::S_CHI;
        end else begin
          state_nxt = bfrc_pkg::S_COUT;
        end
      end
      bfrc_pkg::S_CHI: begin
        acc_nxt  = add_sum;
        pend_nxt = 1'b0;
        if (hi_r[0]) begin
          hi_m     = hi_r - (NW + 1)'(1);
          rd_addr  = hi_m[NW-1:0];
          pend_nxt = 1'b1;
        end
        lo_nxt    = lo_r >> 1;
        hi_nxt    = hi_m >> 1;
        state_nxt = bfrc_pkg::S_CLO;
      end
      bfrc_pkg::S_COUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = err_r ? '0 : acc_r;
          out_err_nxt   = err_r;
          state_nxt     = bfrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfrc_pkg::S_IDLE;
      end
    endcase

    if (cfg_acc) begin
      active_size_nxt = cfg_size;
      clr_nxt         = '0;
      state_nxt       = bfrc_pkg::S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bfrc_pkg::S_CLR;
      active_size_r <= SW'(bfrc_pkg::SIZE);
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      active_size_r <= active_size_nxt;
      clr_r         <= clr_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    acc_r       <= acc_nxt;
    err_r       <= err_nxt;
    pend_r      <= pend_nxt;
    leaf_r      <= leaf_nxt;
    up_r        <= up_nxt;
    out_count_r <= out_count_nxt;
    out_err_r   <= out_err_nxt;
  end

  `BFRC_ASSERT_SAME(a_lo_not_past_hi, (state_r == bfrc_pkg::S_CLO || state_r == bfrc_pkg::S_CHI), (lo_r <= hi_r))
  `BFRC_ASSERT_NEXT(a_bad_count_to_out, (in_acc && in_tuser == bfrc_pkg::OP_COUNT && cnt_bad && !cfg_acc), (state_r == bfrc_pkg::S_COUT))
  `BFRC_ASSERT_NEXT(a_clear_ends_idle, (state_r == bfrc_pkg::S_CLR && clr_r == '1 && !cfg_acc), (state_r == bfrc_pkg::S_IDLE))
  `BFRC_ASSERT_SAME(a_error_zero_count, (out_valid_r && out_err_r), (out_count_r == '0))
  `BFRC_ASSERT_SAME(a_walk_no_clear_write, (state_r == bfrc_pkg::S_FWR), (wr_en && wr_addr == node_r && node_r != '0))

endmodule
`default_nettype wire
